>>> rtl/bfi_pkg.sv
// Shared types and constants of the integral box filter.
// Used by the front, the queue and the back of the filter. No dependencies.
package bfi_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int SLOT_W     = 4;                // 16 row slots >= 2*7+2
	localparam int K_W        = 4;                // kernel side, up to 15
	localparam int CS_W       = 12;               // column sum of up to 15 pixels
	localparam int SUM_W      = 16;
	localparam int HIST_N     = 15;               // column sums kept for the row window
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_SCALE  = 2'd3
	} reg_idx_t;

	// One classified pixel, from front to back.
	typedef struct packed {
		logic [7:0]        pixel;
		logic [COL_W-1:0]  x;
		logic [SLOT_W-1:0] y_slot;
		logic [SLOT_W-1:0] old_slot;
		logic              y_zero;
		logic              sub_row;
		logic              sub_col;
		logic [K_W-1:0]    k;
		logic              emit;
		logic              last;
		logic [COL_W-1:0]  ocol;
		logic [ROW_W-1:0]  orow;
	} pix_req_t;

endpackage

>>> rtl/box_filter_integral_byte_stream.sv
// Box filter over a padded 8-bit raster stream, one pixel per clock unless in_stall.
// An accepted request passes the queue, stage 1, stage 2 and the output register.
// Throughput: one request per cycle while not in_stall; the back pipeline advances
// whenever the output register is free, the 4-entry queue absorbs output stalls.
// Reset (arst_n, async low): counters, queue and valids clear, registers take
// their defaults; line store contents are don't-care until written.
module box_filter_integral_byte_stream import bfi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	// pixel request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        pixel,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SUM_W-1:0]  box_sum,
	output logic [15:0]       box_mean,
	output logic [COL_W-1:0]  out_col,
	output logic [ROW_W-1:0]  out_row,
	output logic              last_of_frame
);

	pix_req_t    fr_req;
	pix_req_t    hd_req;
	logic        q_full;
	logic        q_nonempty;
	logic        q_pop;
	logic        acc;
	logic [15:0] scale;

	// Config writes must be issued only while idle; not enforced, so always take them.
	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign acc       = in_valid && !q_full;

	// Front: counters and per-pixel classification (window, slots, last).
	bfi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.pixel     (pixel),
		.req       (fr_req),
		.scale     (scale)
	);

	bfi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.wr       (fr_req),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd       (hd_req)
	);

	// Back: column sums over the line store, running row window, mean.
	bfi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.hd_valid      (q_nonempty),
		.hd            (hd_req),
		.pop           (q_pop),
		.scale         (scale),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.box_sum       (box_sum),
		.box_mean      (box_mean),
		.out_col       (out_col),
		.out_row       (out_row),
		.last_of_frame (last_of_frame)
	);

endmodule

>>> rtl/bfi_front.sv
// Front of the box filter: configuration registers, raster counters and
// classification of each pixel. Depends on bfi_pkg.
module bfi_front import bfi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             acc,
	input  logic [7:0]       pixel,
	output pix_req_t         req,
	output logic [15:0]      scale
);

	logic [10:0]      width_q;
	logic [12:0]      height_q;
	logic [2:0]       radius_q;
	logic [15:0]      scale_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic [3:0]  r2;
	logic [3:0]  k;
	logic [10:0] col_nx;
	logic [12:0] row_nx;

	always_comb begin
		w_eff = (width_q == 11'd0) ? 11'd1 :
			(width_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_q;
		h_eff = (height_q == 13'd0) ? 13'd1 :
			(height_q > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_q;
		r2 = {radius_q, 1'b0};
		k = r2 + 4'd1;
		col_nx = {1'b0, col_q} + 11'd1;
		row_nx = {1'b0, row_q} + 13'd1;
	end

	always_comb begin
		req.pixel    = pixel;
		req.x        = col_q;
		req.y_slot   = row_q[SLOT_W-1:0];
		req.old_slot = row_q[SLOT_W-1:0] - k;
		req.y_zero   = (row_q == '0);
		req.sub_row  = (row_q >= ROW_W'(k));
		req.sub_col  = (col_q >= COL_W'(k));
		req.k        = k;
		req.emit     = (col_q >= COL_W'(r2)) && (row_q >= ROW_W'(r2));
		req.last     = (col_nx == w_eff) && (row_nx == h_eff);
		req.ocol     = col_q - COL_W'(r2);
		req.orow     = row_q - ROW_W'(r2);
	end

	assign scale = scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			radius_q <= 3'd1;
			scale_q  <= 16'd7282;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_SCALE:  scale_q  <= cfg_data;
				default:    width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_nx >= w_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= h_eff) ? '0 : row_nx[ROW_W-1:0];
			end else begin
				col_q <= col_nx[COL_W-1:0];
			end
		end
	end

endmodule

>>> rtl/bfi_queue.sv
// Short request queue between front and back of the box filter.
// Depends on bfi_pkg.
module bfi_queue import bfi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_req_t wr,
	output logic     full,
	input  logic     pop,
	output logic     nonempty,
	output pix_req_t rd
);

	pix_req_t           ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full     = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
		end
	end

endmodule

>>> rtl/bfi_back.sv
// Back of the box filter: pixel line store, column sums, row window sum,
// mean multiply and output register. Depends on bfi_pkg.
module bfi_back import bfi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hd_valid,
	input  pix_req_t          hd,
	output logic              pop,
	input  logic [15:0]       scale,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SUM_W-1:0]  box_sum,
	output logic [15:0]       box_mean,
	output logic [COL_W-1:0]  out_col,
	output logic [ROW_W-1:0]  out_row,
	output logic              last_of_frame
);

	logic [7:0]      pix_mem [(1 << SLOT_W) * MAX_WIDTH];
	logic [CS_W-1:0] cs_mem  [MAX_WIDTH];

	logic adv;

	logic            valid_s1;
	pix_req_t        ent_s1;
	logic [7:0]      pix_rd_s1;
	logic [CS_W-1:0] cs_rd_s1;
	logic            pfwd_s1;
	logic [7:0]      pfwd_val_s1;
	logic            cfwd_s1;
	logic [CS_W-1:0] cfwd_val_s1;

	logic [CS_W-1:0]  cs_hist_q [HIST_N];
	logic [SUM_W-1:0] hsum_q;

	logic [7:0]       pold;
	logic [CS_W-1:0]  base;
	logic [CS_W-1:0]  cs_new;
	logic [CS_W-1:0]  tap;
	logic [SUM_W-1:0] h_new;

	logic             valid_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic             last_s2;

	logic [31:0] prod;

	assign adv = !(out_valid && out_stall);
	assign pop = adv && hd_valid;

	always_comb begin
		pold   = pfwd_s1 ? pfwd_val_s1 : pix_rd_s1;
		base   = ent_s1.y_zero ? '0 : (cfwd_s1 ? cfwd_val_s1 : cs_rd_s1);
		cs_new = base + CS_W'(ent_s1.pixel) - (ent_s1.sub_row ? CS_W'(pold) : '0);
		tap    = cs_hist_q[ent_s1.k - 4'd1];
		h_new  = ((ent_s1.x == '0) ? '0 : hsum_q) + SUM_W'(cs_new)
			- (ent_s1.sub_col ? SUM_W'(tap) : '0);
		prod   = 32'(sum_s2) * 32'(scale);
	end

	// Stores, read with registered data; the pixel and column sum just written
	// by stage 1 are forwarded when the next read hits the same place.
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_rd_s1   <= pix_mem[{hd.old_slot, hd.x}];
			cs_rd_s1    <= cs_mem[hd.x];
			ent_s1      <= hd;
			pfwd_s1     <= valid_s1 && ent_s1.y_slot == hd.old_slot && ent_s1.x == hd.x;
			pfwd_val_s1 <= ent_s1.pixel;
			cfwd_s1     <= valid_s1 && ent_s1.x == hd.x;
			cfwd_val_s1 <= cs_new;
			if (valid_s1) begin
				pix_mem[{ent_s1.y_slot, ent_s1.x}] <= ent_s1.pixel;
				cs_mem[ent_s1.x] <= cs_new;
				hsum_q <= h_new;
				cs_hist_q[0] <= cs_new;
				for (int i = 1; i < HIST_N; i++) cs_hist_q[i] <= cs_hist_q[i-1];
			end
			sum_s2   <= h_new;
			col_s2   <= ent_s1.ocol;
			row_s2   <= ent_s1.orow;
			last_s2  <= ent_s1.last;
			box_sum  <= sum_s2;
			box_mean <= prod[31:16];
			out_col  <= col_s2;
			out_row  <= row_s2;
			last_of_frame <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= hd_valid;
			valid_s2  <= valid_s1 && ent_s1.emit;
			out_valid <= valid_s2;
		end
	end

endmodule

>>> rtl/bfi_checker.sv
// Port-level checks for the box filter, bound to the top level.
// Depends on box_filter_integral_byte_stream.
module bfi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] box_sum
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

	a_hold_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(box_sum)) else $error("sum changed under stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("config port not ready");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid) else $error("result during reset");

endmodule

bind box_filter_integral_byte_stream bfi_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.box_sum   (box_sum)
);
